[rtl/cau_pkg.sv]
// Shared definitions for the complex arithmetic unit.
// Action and status codes, the decoded operation type and its decoder.
`timescale 1ns / 1ps

package cau_pkg;

   localparam int ACT_W = 3;

   localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
   localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
   localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
   localparam logic [ACT_W-1:0] ACT_DIV = 3'd3;
   localparam logic [ACT_W-1:0] ACT_EQ  = 3'd4;
   localparam logic [ACT_W-1:0] ACT_MAG = 3'd5;

   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DIV0 = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic add;
      logic sub;
      logic mul;
      logic div;
      logic eq;
      logic mag;
   } op_type;

   localparam int OP_W = $bits(op_type);

   function automatic op_type decode_action(input logic [ACT_W-1:0] act);
      op_type op;
      op = '0;
      unique case (act)
         ACT_ADD: op.add = 1'b1;
         ACT_SUB: op.sub = 1'b1;
         ACT_MUL: op.mul = 1'b1;
         ACT_DIV: op.div = 1'b1;
         ACT_EQ:  op.eq  = 1'b1;
         ACT_MAG: op.mag = 1'b1;
         default: op = '0;
      endcase
      return op;
   endfunction

endpackage

[rtl/cau_req_if.sv]
// Request channel of the complex arithmetic unit: valid, ready and one item.
// Depends on cau_pkg for the action width.
`timescale 1ns / 1ps

interface cau_req_if #(parameter int DATA_WIDTH = 32);
   logic                           valid;
   logic                           ready;
   logic [cau_pkg::ACT_W-1:0]      action;
   logic signed [DATA_WIDTH-1:0]   a_re;
   logic signed [DATA_WIDTH-1:0]   a_im;
   logic signed [DATA_WIDTH-1:0]   b_re;
   logic signed [DATA_WIDTH-1:0]   b_im;

   modport source (output valid, action, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, action, a_re, a_im, b_re, b_im, output ready);
endinterface

[rtl/cau_rsp_if.sv]
// Response channel of the complex arithmetic unit: valid, ready and one item.
// Depends on cau_pkg for the status width.
`timescale 1ns / 1ps

interface cau_rsp_if #(parameter int DATA_WIDTH = 32);
   logic                           valid;
   logic                           ready;
   logic signed [DATA_WIDTH-1:0]   res_re;
   logic signed [DATA_WIDTH-1:0]   res_im;
   logic                           is_equal;
   logic [cau_pkg::STATUS_W-1:0]   status;

   modport source (output valid, res_re, res_im, is_equal, status, input ready);
   modport sink   (input valid, res_re, res_im, is_equal, status, output ready);
endinterface

[rtl/cau_front.sv]
// Front stage: accepts request items, decodes the action and registers them.
// Depends on cau_pkg and cau_req_if.
`timescale 1ns / 1ps

module cau_front #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                           clock,
   input  logic                                           reset,
   cau_req_if.sink                                        req_ch,
   output logic                                           out_valid,
   input  logic                                           out_ready,
   output logic [cau_pkg::OP_W+4*DATA_WIDTH-1:0]          out_data
);
   import cau_pkg::*;

   localparam int EW = OP_W + 4 * DATA_WIDTH;

   logic          valid_ff;
   logic          valid_in;
   logic [EW-1:0] data_ff;
   logic [EW-1:0] data_in;
   logic          take;

   assign req_ch.ready = !valid_ff || out_ready;
   assign take         = req_ch.valid && req_ch.ready;
   assign valid_in     = req_ch.ready ? req_ch.valid : valid_ff;
   assign data_in      = {decode_action(req_ch.action), req_ch.a_re, req_ch.a_im,
                          req_ch.b_re, req_ch.b_im};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/cau_queue.sv]
// Short FIFO between the front and back parts of the complex arithmetic unit.
// It depends on no other file of the project.
`timescale 1ns / 1ps

module cau_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic [PW-1:0]    wr_ptr_in;
   logic [PW-1:0]    rd_ptr_in;
   logic [CW-1:0]    count_in;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != FULL;
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/cau_back.sv]
// Back part: multiply stage, combine stage, bit-serial divide and square root
// stages, and the output register. Depends on cau_pkg and cau_rsp_if.
`timescale 1ns / 1ps

module cau_back #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           in_valid,
   output logic                                           in_ready,
   input  logic [cau_pkg::OP_W+4*DATA_WIDTH-1:0]          in_data,
   cau_rsp_if.source                                      rsp_ch
);
   import cau_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int PW = 2 * W;
   localparam int NW = 2 * W + 1;
   localparam int DW = 2 * W + 1;
   localparam int RW = NW + FRAC_BITS;

   localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      op_type        op;
      logic [W-1:0]  re;
      logic [W-1:0]  im;
      logic          eq;
      logic          sat;
      logic          den_zero;
      logic          neg_re;
      logic          neg_im;
      logic          ovf_re;
      logic          ovf_im;
      logic [DW-1:0] den;
      logic [DW-1:0] rem_re;
      logic [DW-1:0] rem_im;
      logic [W-1:0]  nlo_re;
      logic [W-1:0]  nlo_im;
      logic [W-1:0]  q_re;
      logic [W-1:0]  q_im;
      logic [PW-1:0] s;
      logic [W:0]    srem;
      logic [W-1:0]  root;
   } step_type;

   function automatic logic [W:0] clamp(input logic signed [NW-1:0] v);
      logic all_ones;
      logic all_zeros;
      all_ones  = &v[NW-1:W-1];
      all_zeros = ~|v[NW-1:W-1];
      if (all_ones || all_zeros) begin
         return {1'b0, v[W-1:0]};
      end else if (v[NW-1]) begin
         return {1'b1, MIN_VAL};
      end else begin
         return {1'b1, MAX_VAL};
      end
   endfunction

   function automatic logic [W:0] quot_out(input logic neg, input logic ovf,
                                           input logic [W-1:0] q);
      logic [W-1:0] nq;
      nq = -q;
      if (!neg) begin
         if (ovf || q[W-1]) begin
            return {1'b1, MAX_VAL};
         end else begin
            return {1'b0, q};
         end
      end else if (ovf || (q[W-1] && (|q[W-2:0]))) begin
         return {1'b1, MIN_VAL};
      end else begin
         return {1'b0, nq};
      end
   endfunction

   function automatic step_type step_fn(input step_type x);
      step_type      y;
      logic [DW:0]   t_re;
      logic [DW:0]   t_im;
      logic [DW:0]   d_ext;
      logic          ge_re;
      logic          ge_im;
      logic [W+2:0]  t_s;
      logic [W+2:0]  trial;
      logic          ge_s;
      logic [DW:0]   diff_re;
      logic [DW:0]   diff_im;
      logic [W+2:0]  diff_s;
      y       = x;
      d_ext   = {1'b0, x.den};
      t_re    = {x.rem_re, x.nlo_re[W-1]};
      t_im    = {x.rem_im, x.nlo_im[W-1]};
      ge_re   = t_re >= d_ext;
      ge_im   = t_im >= d_ext;
      diff_re = t_re - d_ext;
      diff_im = t_im - d_ext;
      y.rem_re = ge_re ? diff_re[DW-1:0] : t_re[DW-1:0];
      y.rem_im = ge_im ? diff_im[DW-1:0] : t_im[DW-1:0];
      y.q_re   = {x.q_re[W-2:0], ge_re};
      y.q_im   = {x.q_im[W-2:0], ge_im};
      y.nlo_re = {x.nlo_re[W-2:0], 1'b0};
      y.nlo_im = {x.nlo_im[W-2:0], 1'b0};
      t_s      = {x.srem, x.s[PW-1:PW-2]};
      trial    = {1'b0, x.root, 2'b01};
      ge_s     = t_s >= trial;
      diff_s   = t_s - trial;
      y.srem   = ge_s ? diff_s[W:0] : t_s[W:0];
      y.root   = {x.root[W-2:0], ge_s};
      y.s      = {x.s[PW-3:0], 2'b00};
      return y;
   endfunction

   logic adv;

   // Multiply stage.
   op_type              in_op;
   logic signed [W-1:0] in_are;
   logic signed [W-1:0] in_aim;
   logic signed [W-1:0] in_bre;
   logic signed [W-1:0] in_bim;
   logic signed [W-1:0] sq_x0;
   logic signed [W-1:0] sq_x1;

   logic                 m_valid_ff;
   op_type               m_op_ff;
   logic signed [W-1:0]  m_are_ff;
   logic signed [W-1:0]  m_aim_ff;
   logic signed [W-1:0]  m_bre_ff;
   logic signed [W-1:0]  m_bim_ff;
   logic signed [PW-1:0] m_prr_ff;
   logic signed [PW-1:0] m_pii_ff;
   logic signed [PW-1:0] m_pri_ff;
   logic signed [PW-1:0] m_pir_ff;
   logic signed [PW-1:0] m_sq0_ff;
   logic signed [PW-1:0] m_sq1_ff;

   assign adv      = !rsp_ch.valid || rsp_ch.ready;
   assign in_ready = adv;

   assign {in_op, in_are, in_aim, in_bre, in_bim} = in_data;
   assign sq_x0 = in_op.mag ? in_are : in_bre;
   assign sq_x1 = in_op.mag ? in_aim : in_bim;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_op_ff  <= in_op;
         m_are_ff <= in_are;
         m_aim_ff <= in_aim;
         m_bre_ff <= in_bre;
         m_bim_ff <= in_bim;
         m_prr_ff <= PW'(in_are) * PW'(in_bre);
         m_pii_ff <= PW'(in_aim) * PW'(in_bim);
         m_pri_ff <= PW'(in_are) * PW'(in_bim);
         m_pir_ff <= PW'(in_aim) * PW'(in_bre);
         m_sq0_ff <= PW'(sq_x0) * PW'(sq_x0);
         m_sq1_ff <= PW'(sq_x1) * PW'(sq_x1);
      end
   end

   // Combine stage.
   logic signed [W:0]    xa_re;
   logic signed [W:0]    xa_im;
   logic signed [W:0]    xb_re;
   logic signed [W:0]    xb_im;
   logic signed [W:0]    s_re;
   logic signed [W:0]    s_im;
   logic signed [NW-1:0] mre;
   logic signed [NW-1:0] mim;
   logic signed [NW-1:0] nre;
   logic signed [NW-1:0] nim;
   logic [W:0]           c_re;
   logic [W:0]           c_im;
   logic [W-1:0]         a_re_in;
   logic [W-1:0]         a_im_in;
   logic                 a_sat_in;
   logic [DW-1:0]        sqsum;

   logic                 a_valid_ff;
   op_type               a_op_ff;
   logic [W-1:0]         a_re_ff;
   logic [W-1:0]         a_im_ff;
   logic                 a_eq_ff;
   logic                 a_sat_ff;
   logic                 a_neg_re_ff;
   logic                 a_neg_im_ff;
   logic [NW-1:0]        a_mag_re_ff;
   logic [NW-1:0]        a_mag_im_ff;
   logic [DW-1:0]        a_den_ff;

   always_comb begin
      xa_re = {m_are_ff[W-1], m_are_ff};
      xa_im = {m_aim_ff[W-1], m_aim_ff};
      xb_re = {m_bre_ff[W-1], m_bre_ff};
      xb_im = {m_bim_ff[W-1], m_bim_ff};
      s_re  = m_op_ff.sub ? xa_re - xb_re : xa_re + xb_re;
      s_im  = m_op_ff.sub ? xa_im - xb_im : xa_im + xb_im;
      mre   = (NW'(m_prr_ff) - NW'(m_pii_ff)) >>> FRAC_BITS;
      mim   = (NW'(m_pri_ff) + NW'(m_pir_ff)) >>> FRAC_BITS;
      nre   = NW'(m_prr_ff) + NW'(m_pii_ff);
      nim   = NW'(m_pir_ff) - NW'(m_pri_ff);
      sqsum = DW'($unsigned(m_sq0_ff)) + DW'($unsigned(m_sq1_ff));
      if (m_op_ff.mul) begin
         c_re = clamp(mre);
         c_im = clamp(mim);
      end else begin
         c_re = clamp(NW'(s_re));
         c_im = clamp(NW'(s_im));
      end
      if (m_op_ff.add || m_op_ff.sub || m_op_ff.mul) begin
         a_re_in  = c_re[W-1:0];
         a_im_in  = c_im[W-1:0];
         a_sat_in = c_re[W] || c_im[W];
      end else begin
         a_re_in  = '0;
         a_im_in  = '0;
         a_sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_op_ff     <= m_op_ff;
         a_re_ff     <= a_re_in;
         a_im_ff     <= a_im_in;
         a_sat_ff    <= a_sat_in;
         a_eq_ff     <= m_op_ff.eq && (m_are_ff == m_bre_ff) && (m_aim_ff == m_bim_ff);
         a_neg_re_ff <= nre[NW-1];
         a_neg_im_ff <= nim[NW-1];
         a_mag_re_ff <= nre[NW-1] ? NW'(-nre) : NW'(nre);
         a_mag_im_ff <= nim[NW-1] ? NW'(-nim) : NW'(nim);
         a_den_ff    <= sqsum;
      end
   end

   // Divider and square root set-up, then one quotient and root bit per stage.
   logic [RW-1:0] nfull_re;
   logic [RW-1:0] nfull_im;
   logic [RW-1:0] nhi_re;
   logic [RW-1:0] nhi_im;
   logic [RW-1:0] den_x;
   step_type      step0_in;

   logic          step_valid_ff [W+1];
   step_type      step_ff       [W+1];

   always_comb begin
      nfull_re = RW'(a_mag_re_ff) << FRAC_BITS;
      nfull_im = RW'(a_mag_im_ff) << FRAC_BITS;
      nhi_re   = nfull_re >> W;
      nhi_im   = nfull_im >> W;
      den_x    = RW'(a_den_ff);
      step0_in          = '0;
      step0_in.op       = a_op_ff;
      step0_in.re       = a_re_ff;
      step0_in.im       = a_im_ff;
      step0_in.eq       = a_eq_ff;
      step0_in.sat      = a_sat_ff;
      step0_in.den_zero = a_den_ff == '0;
      step0_in.neg_re   = a_neg_re_ff;
      step0_in.neg_im   = a_neg_im_ff;
      step0_in.ovf_re   = nhi_re >= den_x;
      step0_in.ovf_im   = nhi_im >= den_x;
      step0_in.den      = a_den_ff;
      step0_in.rem_re   = step0_in.ovf_re ? '0 : nhi_re[DW-1:0];
      step0_in.rem_im   = step0_in.ovf_im ? '0 : nhi_im[DW-1:0];
      step0_in.nlo_re   = nfull_re[W-1:0];
      step0_in.nlo_im   = nfull_im[W-1:0];
      step0_in.s        = a_den_ff[PW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         step_valid_ff[0] <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         step_ff[0] <= step0_in;
      end
   end

   for (genvar k = 0; k < W; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            step_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            step_valid_ff[k+1] <= step_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            step_ff[k+1] <= step_fn(step_ff[k]);
         end
      end
   end

   // Result selection and output register.
   step_type               fin;
   logic [W:0]             qo_re;
   logic [W:0]             qo_im;
   logic [W-1:0]           res_re_in;
   logic [W-1:0]           res_im_in;
   logic                   is_equal_in;
   logic [STATUS_W-1:0]    status_in;
   logic                   sat;

   logic                   out_valid_ff;
   logic [W-1:0]           res_re_ff;
   logic [W-1:0]           res_im_ff;
   logic                   is_equal_ff;
   logic [STATUS_W-1:0]    status_ff;

   always_comb begin
      fin         = step_ff[W];
      qo_re       = quot_out(fin.neg_re, fin.ovf_re, fin.q_re);
      qo_im       = quot_out(fin.neg_im, fin.ovf_im, fin.q_im);
      res_re_in   = fin.re;
      res_im_in   = fin.im;
      is_equal_in = fin.eq;
      sat         = fin.sat;
      if (fin.op.div) begin
         if (fin.den_zero) begin
            res_re_in = '0;
            res_im_in = '0;
            sat       = 1'b0;
         end else begin
            res_re_in = qo_re[W-1:0];
            res_im_in = qo_im[W-1:0];
            sat       = qo_re[W] || qo_im[W];
         end
      end else if (fin.op.mag) begin
         res_re_in = fin.root[W-1] ? MAX_VAL : fin.root;
         res_im_in = '0;
         sat       = fin.root[W-1];
      end
      if (fin.op.div && fin.den_zero) begin
         status_in = ST_DIV0;
      end else if (sat) begin
         status_in = ST_SAT;
      end else begin
         status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= step_valid_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_re_ff   <= res_re_in;
         res_im_ff   <= res_im_in;
         is_equal_ff <= is_equal_in;
         status_ff   <= status_in;
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.res_re   = res_re_ff;
   assign rsp_ch.res_im   = res_im_ff;
   assign rsp_ch.is_equal = is_equal_ff;
   assign rsp_ch.status   = status_ff;

endmodule

[rtl/complex_arithmetic_unit.sv]
// Complex arithmetic unit on signed fixed-point operands.
// Requests enter on req_ch, results leave on rsp_ch; both are valid/ready channels and
// an item moves at a rising clock edge where valid and ready are both high.
// Each request carries an action (add, subtract, multiply, divide, equal, magnitude of a)
// and two complex operands; it gives exactly one response item, in request order.
// A new item is accepted every cycle while the response side keeps up.
// On its way from acceptance to a valid response an item passes one front
// register, the queue, a multiply stage, a combine stage, a divider set-up stage,
// DATA_WIDTH one-bit divide and square-root stages, and the output register.
// The divide and square-root stages set the latency; all actions take the same path.
// When the receiver holds rsp_ch.ready low with a response waiting, the back pipeline
// holds still, the two-entry queue fills, and then the front stops accepting.
// Reset clears every valid flag and the queue pointers; no item is in flight after it.
// Depends on cau_pkg, cau_req_if, cau_rsp_if, cau_front, cau_queue and cau_back.
`timescale 1ns / 1ps

module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   cau_req_if.sink     req_ch,
   cau_rsp_if.source   rsp_ch
);
   import cau_pkg::*;

   localparam int EW = OP_W + 4 * DATA_WIDTH;

   logic          f_valid;
   logic          f_ready;
   logic [EW-1:0] f_data;
   logic          q_valid;
   logic          q_ready;
   logic [EW-1:0] q_data;

   cau_front #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_data  (f_data)
   );

   cau_queue #(
      .WIDTH(EW),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   cau_back #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (q_valid),
      .in_ready (q_ready),
      .in_data  (q_data),
      .rsp_ch   (rsp_ch)
   );

endmodule

[dv/tb.sv]
// Self-checking testbench for the complex arithmetic unit.
// Depends on cau_pkg, cau_req_if, cau_rsp_if and complex_arithmetic_unit.
`timescale 1ns / 1ps

module tb;
   import cau_pkg::*;

   localparam int DW   = 32;
   localparam int FB   = 16;
   localparam int LAT  = DW + 5;
   localparam int NRND = 1800;

   localparam logic [ACT_W-1:0] ACT_RSVD_6 = 3'd6;
   localparam logic [ACT_W-1:0] ACT_RSVD_7 = 3'd7;

   typedef struct {
      logic [ACT_W-1:0]  action;
      logic signed [DW-1:0] a_re, a_im, b_re, b_im;
   } op_item_type;

   typedef struct {
      logic signed [DW-1:0]  res_re, res_im;
      logic                  is_equal;
      logic [STATUS_W-1:0]   status;
   } res_item_type;

   class cau_scoreboard;
      res_item_type pending[$];
      int           mismatches;

      function automatic logic signed [DW-1:0] clamp(input logic signed [127:0] x,
                                                     inout bit sat);
         logic signed [127:0] hi, lo;
         hi = (128'sd1 <<< (DW - 1)) - 1;
         lo = -(128'sd1 <<< (DW - 1));
         if (x > hi) begin
            sat = 1;
            return hi[DW-1:0];
         end
         if (x < lo) begin
            sat = 1;
            return lo[DW-1:0];
         end
         return x[DW-1:0];
      endfunction

      function automatic res_item_type predict(op_item_type q);
         logic signed [127:0] ar, ai, br, bi, den, s, root, c;
         bit sat;
         res_item_type r;
         ar = q.a_re;
         ai = q.a_im;
         br = q.b_re;
         bi = q.b_im;
         sat = 0;
         r.res_re = '0;
         r.res_im = '0;
         r.is_equal = 1'b0;
         r.status = ST_OK;
         case (q.action)
            ACT_ADD: begin
               r.res_re = clamp(ar + br, sat);
               r.res_im = clamp(ai + bi, sat);
            end
            ACT_SUB: begin
               r.res_re = clamp(ar - br, sat);
               r.res_im = clamp(ai - bi, sat);
            end
            ACT_MUL: begin
               r.res_re = clamp((ar * br - ai * bi) >>> FB, sat);
               r.res_im = clamp((ar * bi + ai * br) >>> FB, sat);
            end
            ACT_DIV: begin
               den = br * br + bi * bi;
               if (den == 0) begin
                  r.status = ST_DIV0;
               end else begin
                  r.res_re = clamp(((ar * br + ai * bi) <<< FB) / den, sat);
                  r.res_im = clamp(((ai * br - ar * bi) <<< FB) / den, sat);
               end
            end
            ACT_EQ: begin
               r.is_equal = (q.a_re == q.b_re) && (q.a_im == q.b_im);
            end
            ACT_MAG: begin
               s = ar * ar + ai * ai;
               root = 0;
               for (int i = DW; i >= 0; i--) begin
                  c = root | (128'sd1 <<< i);
                  if (c * c <= s) root = c;
               end
               r.res_re = clamp(root, sat);
            end
            default: ;
         endcase
         if (sat) r.status = ST_SAT;
         return r;
      endfunction

      function void note_request(op_item_type q);
         pending.push_back(predict(q));
      endfunction

      function void check_result(res_item_type got);
         res_item_type exp_r;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: re=%h im=%h eq=%b st=%0d",
                        got.res_re, got.res_im, got.is_equal, got.status);
            return;
         end
         exp_r = pending.pop_front();
         if (exp_r.res_re !== got.res_re || exp_r.res_im !== got.res_im ||
             exp_r.is_equal !== got.is_equal || exp_r.status !== got.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: exp re=%h im=%h eq=%b st=%0d, got re=%h im=%h eq=%b st=%0d",
                        exp_r.res_re, exp_r.res_im, exp_r.is_equal, exp_r.status,
                        got.res_re, got.res_im, got.is_equal, got.status);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   cau_req_if #(.DATA_WIDTH(DW)) req_ch ();
   cau_rsp_if #(.DATA_WIDTH(DW)) rsp_ch ();

   complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   cau_scoreboard sb = new();
   int  sent_count;
   bit  stim_done;
   bit  calm_phase;

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm_phase || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [DW-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return {1'b0, {(DW-1){1'b1}}};
         1: return {1'b1, {(DW-1){1'b0}}};
         2: return '0;
         3, 4: return $signed($urandom_range(0, 8 << FB)) - $signed(4 << FB);
         5: return $signed($urandom_range(0, 2 << FB)) - $signed(1 << FB);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_item(op_item_type q);
      req_ch.valid  <= 1'b1;
      req_ch.action <= q.action;
      req_ch.a_re   <= q.a_re;
      req_ch.a_im   <= q.a_im;
      req_ch.b_re   <= q.b_re;
      req_ch.b_im   <= q.b_im;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(q);
      sent_count++;
   endtask

   task automatic send_with_gap(op_item_type q);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      send_item(q);
   endtask

   function automatic op_item_type make_item(logic [ACT_W-1:0] act,
                                             logic signed [DW-1:0] ar,
                                             logic signed [DW-1:0] ai,
                                             logic signed [DW-1:0] br,
                                             logic signed [DW-1:0] bi);
      op_item_type q;
      q.action = act;
      q.a_re = ar;
      q.a_im = ai;
      q.b_re = br;
      q.b_im = bi;
      return q;
   endfunction

   initial begin
      logic signed [DW-1:0] mx, mn, one;
      op_item_type q;
      mx = {1'b0, {(DW-1){1'b1}}};
      mn = {1'b1, {(DW-1){1'b0}}};
      one = 1 << FB;
      clock = 1'b0;
      reset = 1'b1;
      calm_phase = 1'b0;
      req_ch.valid <= 1'b0;
      req_ch.action <= ACT_ADD;
      req_ch.a_re <= '0;
      req_ch.a_im <= '0;
      req_ch.b_re <= '0;
      req_ch.b_im <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_with_gap(make_item(ACT_ADD, mx, mn, mx, mn));
      send_with_gap(make_item(ACT_ADD, one, -one, 3 * one, one));
      send_with_gap(make_item(ACT_SUB, mn, mx, mx, mn));
      send_with_gap(make_item(ACT_SUB, mx, -1, mn, 1));
      send_with_gap(make_item(ACT_MUL, mx, mx, mx, mn));
      send_with_gap(make_item(ACT_MUL, mn, mn, mn, mn));
      send_with_gap(make_item(ACT_MUL, -one, 2 * one, -1, 3));
      send_with_gap(make_item(ACT_DIV, one, one, 0, 0));
      send_with_gap(make_item(ACT_DIV, mx, mn, 1, 0));
      send_with_gap(make_item(ACT_DIV, -3 * one, one, one, -2 * one));
      send_with_gap(make_item(ACT_DIV, mn, mn, mn, mn));
      send_with_gap(make_item(ACT_DIV, 5, -7, mx, 1));
      send_with_gap(make_item(ACT_EQ, mn, mx, mn, mx));
      send_with_gap(make_item(ACT_EQ, mn, mx, mn, mx - 1));
      send_with_gap(make_item(ACT_MAG, mn, mn, 0, 0));
      send_with_gap(make_item(ACT_MAG, mx, 0, 0, 0));
      send_with_gap(make_item(ACT_MAG, 3 * one, -4 * one, 0, 0));
      send_with_gap(make_item(ACT_MAG, 0, 0, 0, 0));
      send_with_gap(make_item(ACT_RSVD_6, mx, mn, one, one));
      send_with_gap(make_item(ACT_RSVD_7, one, mn, mx, 0));

      for (int n = 0; n < NRND; n++) begin
         if (n % 300 == 0) calm_phase = ($urandom_range(0, 2) == 0);
         q = make_item(ACT_W'($urandom_range(0, 7)), pick_value(), pick_value(),
                       pick_value(), pick_value());
         if ($urandom_range(0, 15) == 0) begin
            q.b_re = q.a_re;
            q.b_im = q.a_im;
         end
         if ($urandom_range(0, 25) == 0) begin
            q.b_re = '0;
            q.b_im = '0;
         end
         send_with_gap(q);
      end
      req_ch.valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      int stall;
      bit pressed;
      stall = 0;
      pressed = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready && !reset)
            sb.check_result('{rsp_ch.res_re, rsp_ch.res_im, rsp_ch.is_equal, rsp_ch.status});
         if (!pressed && sent_count >= 500) begin
            pressed = 1;
            stall = 300;
         end
         if (stall > 0) begin
            stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   initial begin
      int waited;
      waited = 0;
      wait (stim_done);
      while (sb.pending.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (2 * LAT) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
rtl/cau_pkg.sv
rtl/cau_req_if.sv
rtl/cau_rsp_if.sv
rtl/cau_front.sv
rtl/cau_queue.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit.sv
dv/tb.sv
